[hw/rtl/ufp_pkg.sv]
// Shared types and constants for the unit normal pipeline.
`timescale 1ns / 1ps
`default_nettype none
package ufp_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int FIELD_W = 16;
  localparam int VEC_W = COORD_WIDTH + 1;
  localparam int PROD_W = 2 * VEC_W;
  localparam int MAG_W = PROD_W + 1;
  localparam int LEN_W = $clog2(MAG_W + 1);
  localparam int M_W = 30;
  localparam int SQ_W = 2 * M_W + 2;
  localparam int ROOT_W = SQ_W / 2;
  localparam int Q_W = 16;
  localparam int OUT_W = 16;
  localparam logic [Q_W-1:0] ONE_Q14 = Q_W'(16384);

  typedef struct packed {
    logic signed [FIELD_W-1:0] corner_x;
    logic signed [FIELD_W-1:0] corner_y;
    logic signed [FIELD_W-1:0] corner_z;
    logic signed [FIELD_W-1:0] first_x;
    logic signed [FIELD_W-1:0] first_y;
    logic signed [FIELD_W-1:0] first_z;
    logic signed [FIELD_W-1:0] second_x;
    logic signed [FIELD_W-1:0] second_y;
    logic signed [FIELD_W-1:0] second_z;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] normal_x;
    logic signed [OUT_W-1:0] normal_y;
    logic signed [OUT_W-1:0] normal_z;
    logic                    degenerate;
  } out_t;

  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
  } cross_t;

  typedef struct packed {
    logic [2:0][M_W-1:0] m;
    logic [2:0]          neg;
    logic                degen;
  } unit_t;

  typedef struct packed {
    logic [2:0][Q_W-1:0] q;
    logic [2:0]          neg;
    logic                degen;
  } quot_t;

endpackage
`default_nettype wire

[hw/rtl/unit_normal_from_points.sv]
// Top level: unit surface normal of a corner and two neighbor points.
// Stages in order: cross product, scaling and sum of squares, square root,
// divide and rounding.
// Throughput: one transaction per cycle; the 31-stage root and the 16-stage
// divide are fully pipelined. A stall on the output freezes every stage.
// Reset: synchronous, active high; clears all stage valid bits only.
`timescale 1ns / 1ps
`default_nettype none
module unit_normal_from_points (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ufp_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ufp_pkg::out_t      out_data
);

  localparam int QW = ufp_pkg::Q_W;
  localparam int OW = ufp_pkg::OUT_W;

  // Every stage moves together; hold all of them while a result waits.
  logic advance;

  logic            cross_valid;
  ufp_pkg::cross_t cross_data;
  logic            norm_valid;
  ufp_pkg::unit_t  norm_data;
  logic [ufp_pkg::SQ_W-1:0] norm_sum;
  logic            sqrt_valid;
  ufp_pkg::unit_t  sqrt_data;
  logic [ufp_pkg::ROOT_W-1:0] sqrt_root;
  logic            div_valid;
  ufp_pkg::quot_t  div_data;
  logic [OW-1:0]   comp_next [3];
  logic [QW:0]     rounded [3];
  logic [QW-1:0]   sat [3];

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  ufp_cross u_cross (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_valid (cross_valid),
    .out_data  (cross_data)
  );

  ufp_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (cross_valid),
    .in_data   (cross_data),
    .out_valid (norm_valid),
    .out_data  (norm_data),
    .out_sum   (norm_sum)
  );

  ufp_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (norm_valid),
    .in_data   (norm_data),
    .in_sum    (norm_sum),
    .out_valid (sqrt_valid),
    .out_data  (sqrt_data),
    .out_root  (sqrt_root)
  );

  ufp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (sqrt_valid),
    .in_data   (sqrt_data),
    .in_root   (sqrt_root),
    .out_valid (div_valid),
    .out_data  (div_data)
  );

  // Round half away from zero, clamp to one, restore the sign. A zero
  // cross product forces a zero vector (its divide result is meaningless).
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rounded[i] = ({1'b0, div_data.q[i]} + (QW+1)'(1)) >> 1;
      sat[i] = (rounded[i] > {1'b0, ufp_pkg::ONE_Q14}) ? ufp_pkg::ONE_Q14
                                                      : rounded[i][QW-1:0];
      if (div_data.degen) begin
        comp_next[i] = '0;
      end else if (div_data.neg[i]) begin
        comp_next[i] = OW'(-sat[i]);
      end else begin
        comp_next[i] = OW'(sat[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= div_valid;
    end
    if (advance) begin
      out_data.normal_x   <= comp_next[0];
      out_data.normal_y   <= comp_next[1];
      out_data.normal_z   <= comp_next[2];
      out_data.degenerate <= div_data.degen;
    end
  end

`ifndef SYNTHESIS
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.degenerate |->
      out_data.normal_x == '0 && out_data.normal_y == '0 && out_data.normal_z == '0)
    else $error("degenerate result carries a nonzero component");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      $signed(out_data.normal_x) <= 16384 && $signed(out_data.normal_x) >= -16384 &&
      $signed(out_data.normal_y) <= 16384 && $signed(out_data.normal_y) >= -16384 &&
      $signed(out_data.normal_z) <= 16384 && $signed(out_data.normal_z) >= -16384)
    else $error("normal component outside unit range");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input held off without a stalled result");

  a_reset_clear: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule
`default_nettype wire

[hw/rtl/ufp_cross.sv]
// Edge vectors, cross product and component magnitudes over three stages.
`timescale 1ns / 1ps
`default_nettype none
module ufp_cross (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           advance,
  input  wire logic           in_valid,
  input  wire ufp_pkg::in_t   in_data,
  output logic                out_valid,
  output ufp_pkg::cross_t     out_data
);

  localparam int CW = ufp_pkg::COORD_WIDTH;
  localparam int VW = ufp_pkg::VEC_W;
  localparam int PW = ufp_pkg::PROD_W;
  localparam int MW = ufp_pkg::MAG_W;

  logic signed [VW-1:0] v [3];
  logic signed [VW-1:0] w [3];
  logic signed [PW-1:0] prod [6];
  logic signed [VW-1:0] v_next [3];
  logic signed [VW-1:0] w_next [3];
  logic signed [PW-1:0] prod_next [6];
  logic signed [MW-1:0] n [3];
  logic [CW-1:0] c_raw [3];
  logic [CW-1:0] p_raw [3];
  logic [CW-1:0] q_raw [3];
  logic valid1;
  logic valid2;

  always_comb begin
    c_raw[0] = in_data.corner_x[CW-1:0];
    c_raw[1] = in_data.corner_y[CW-1:0];
    c_raw[2] = in_data.corner_z[CW-1:0];
    p_raw[0] = in_data.first_x[CW-1:0];
    p_raw[1] = in_data.first_y[CW-1:0];
    p_raw[2] = in_data.first_z[CW-1:0];
    q_raw[0] = in_data.second_x[CW-1:0];
    q_raw[1] = in_data.second_y[CW-1:0];
    q_raw[2] = in_data.second_z[CW-1:0];
    for (int i = 0; i < 3; i++) begin
      v_next[i] = $signed({p_raw[i][CW-1], p_raw[i]}) - $signed({c_raw[i][CW-1], c_raw[i]});
      w_next[i] = $signed({q_raw[i][CW-1], q_raw[i]}) - $signed({c_raw[i][CW-1], c_raw[i]});
    end
  end

  always_comb begin
    prod_next[0] = v[1] * w[2];
    prod_next[1] = v[2] * w[1];
    prod_next[2] = v[2] * w[0];
    prod_next[3] = v[0] * w[2];
    prod_next[4] = v[0] * w[1];
    prod_next[5] = v[1] * w[0];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n[i] = $signed({prod[2*i][PW-1], prod[2*i]})
           - $signed({prod[2*i+1][PW-1], prod[2*i+1]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1    <= 1'b0;
      valid2    <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      valid1    <= in_valid;
      valid2    <= valid1;
      out_valid <= valid2;
    end
    if (advance) begin
      v    <= v_next;
      w    <= w_next;
      prod <= prod_next;
      for (int i = 0; i < 3; i++) begin
        out_data.neg[i] <= n[i][MW-1];
        out_data.mag[i] <= n[i][MW-1] ? MW'(-n[i]) : MW'(n[i]);
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/ufp_norm.sv]
// Common scaling of the magnitudes, their squares and the sum of squares.
`timescale 1ns / 1ps
`default_nettype none
module ufp_norm (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             advance,
  input  wire logic             in_valid,
  input  wire ufp_pkg::cross_t  in_data,
  output logic                  out_valid,
  output ufp_pkg::unit_t        out_data,
  output logic [ufp_pkg::SQ_W-1:0] out_sum
);

  localparam int MW = ufp_pkg::MAG_W;
  localparam int LW = ufp_pkg::LEN_W;
  localparam int NW = ufp_pkg::M_W;
  localparam int SW = ufp_pkg::SQ_W;

  logic [MW-1:0] mag_or;
  logic [LW-1:0] len;
  logic [MW+NW-1:0] scaled [3];
  ufp_pkg::unit_t unit_next;
  ufp_pkg::unit_t unit_a;
  ufp_pkg::unit_t unit_b;
  logic [2*NW-1:0] sq [3];
  logic valid_a;
  logic valid_b;

  always_comb begin
    mag_or = in_data.mag[0] | in_data.mag[1] | in_data.mag[2];
    len = '0;
    for (int i = 0; i < MW; i++) begin
      if (mag_or[i]) len = LW'(i + 1);
    end
    for (int i = 0; i < 3; i++) begin
      // Place the leading bit of the largest magnitude at bit M_W-1.
      scaled[i] = {in_data.mag[i], {NW{1'b0}}} >> len;
      unit_next.m[i] = scaled[i][NW-1:0];
    end
    unit_next.neg   = in_data.neg;
    unit_next.degen = (mag_or == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      valid_b   <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      valid_a   <= in_valid;
      valid_b   <= valid_a;
      out_valid <= valid_b;
    end
    if (advance) begin
      unit_a   <= unit_next;
      unit_b   <= unit_a;
      out_data <= unit_b;
      for (int i = 0; i < 3; i++) begin
        sq[i] <= unit_a.m[i] * unit_a.m[i];
      end
      out_sum <= SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);
    end
  end

endmodule
`default_nettype wire

[hw/rtl/ufp_sqrt.sv]
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module ufp_sqrt (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    advance,
  input  wire logic                    in_valid,
  input  wire ufp_pkg::unit_t          in_data,
  input  wire logic [ufp_pkg::SQ_W-1:0] in_sum,
  output logic                         out_valid,
  output ufp_pkg::unit_t               out_data,
  output logic [ufp_pkg::ROOT_W-1:0]   out_root
);

  localparam int SW = ufp_pkg::SQ_W;
  localparam int RW = ufp_pkg::ROOT_W;
  localparam int EW = RW + 2;

  typedef struct packed {
    logic [SW-1:0]  rad;
    logic [EW-1:0]  rem;
    logic [RW-1:0]  root;
    ufp_pkg::unit_t d;
  } sq_stage_t;

  sq_stage_t stage [RW];
  sq_stage_t stage_next [RW];
  logic      stage_valid [RW];

  for (genvar k = 0; k < RW; k++) begin : g_step
    sq_stage_t    src;
    logic         src_valid;
    logic [EW+1:0] shifted;
    logic [EW+1:0] trial;

    if (k == 0) begin : g_first
      assign src = '{rad: in_sum, rem: '0, root: '0, d: in_data};
      assign src_valid = in_valid;
    end else begin : g_rest
      assign src = stage[k-1];
      assign src_valid = stage_valid[k-1];
    end

    always_comb begin
      shifted = {src.rem, src.rad[SW-1 -: 2]};
      trial   = {2'b00, src.root, 2'b01};
      stage_next[k].rad = {src.rad[SW-3:0], 2'b00};
      stage_next[k].d   = src.d;
      if (shifted >= trial) begin
        stage_next[k].rem  = EW'(shifted - trial);
        stage_next[k].root = {src.root[RW-2:0], 1'b1};
      end else begin
        stage_next[k].rem  = shifted[EW-1:0];
        stage_next[k].root = {src.root[RW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stage_valid[k] <= 1'b0;
      end else if (advance) begin
        stage_valid[k] <= src_valid;
      end
      if (advance) begin
        stage[k] <= stage_next[k];
      end
    end
  end

  assign out_valid = stage_valid[RW-1];
  assign out_data  = stage[RW-1].d;
  assign out_root  = stage[RW-1].root;

endmodule
`default_nettype wire

[hw/rtl/ufp_div.sv]
// Pipelined restoring divide of the three scaled components by the length.
`timescale 1ns / 1ps
`default_nettype none
module ufp_div (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     advance,
  input  wire logic                     in_valid,
  input  wire ufp_pkg::unit_t           in_data,
  input  wire logic [ufp_pkg::ROOT_W-1:0] in_root,
  output logic                          out_valid,
  output ufp_pkg::quot_t                out_data
);

  localparam int RW = ufp_pkg::ROOT_W;
  localparam int QW = ufp_pkg::Q_W;
  localparam int NW = ufp_pkg::M_W;

  typedef struct packed {
    logic [RW-1:0]       divisor;
    logic [2:0][RW-1:0]  rem;
    logic [2:0][QW-1:0]  q;
    logic [2:0]          lsb;
    logic [2:0]          neg;
    logic                degen;
  } div_stage_t;

  div_stage_t stage [QW];
  div_stage_t stage_next [QW];
  logic       stage_valid [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    div_stage_t src;
    logic       src_valid;
    logic [RW:0] shifted [3];

    if (k == 0) begin : g_first
      always_comb begin
        src.divisor = in_root;
        src.q       = '0;
        src.neg     = in_data.neg;
        src.degen   = in_data.degen;
        for (int i = 0; i < 3; i++) begin
          // Dividend is m << 15; its top part m >> 1 is already below the divisor.
          src.rem[i] = RW'(in_data.m[i][NW-1:1]);
          src.lsb[i] = in_data.m[i][0];
        end
      end
      assign src_valid = in_valid;
    end else begin : g_rest
      assign src = stage[k-1];
      assign src_valid = stage_valid[k-1];
    end

    always_comb begin
      stage_next[k] = src;
      for (int i = 0; i < 3; i++) begin
        shifted[i] = {src.rem[i], (k == 0) ? src.lsb[i] : 1'b0};
        if (shifted[i] >= {1'b0, src.divisor}) begin
          stage_next[k].rem[i] = RW'(shifted[i] - {1'b0, src.divisor});
          stage_next[k].q[i]   = {src.q[i][QW-2:0], 1'b1};
        end else begin
          stage_next[k].rem[i] = shifted[i][RW-1:0];
          stage_next[k].q[i]   = {src.q[i][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stage_valid[k] <= 1'b0;
      end else if (advance) begin
        stage_valid[k] <= src_valid;
      end
      if (advance) begin
        stage[k] <= stage_next[k];
      end
    end
  end

  assign out_valid      = stage_valid[QW-1];
  assign out_data.q     = stage[QW-1].q;
  assign out_data.neg   = stage[QW-1].neg;
  assign out_data.degen = stage[QW-1].degen;

endmodule
`default_nettype wire
